/* sv/tmq_pkg.sv */
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and codes of the multi-timer expiry queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int FUNC_W    = 3;
    localparam int KIND_W    = 2;
    localparam int SLOT_ID_W = 5;
    localparam int TAG_W     = 8;
    localparam int TIME_W    = 32;
    localparam int MAX_OUT   = 32;

    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SETTAG = 3'd3;
    localparam logic [FUNC_W-1:0] FN_START  = 3'd4;

    localparam logic [KIND_W-1:0] KD_GRANT   = 2'd0;
    localparam logic [KIND_W-1:0] KD_NONE    = 2'd1;
    localparam logic [KIND_W-1:0] KD_EXPIRED = 2'd2;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_ALLOC = 2'd1,
        SLOT_RUN   = 2'd2
    } slot_st_t;

endpackage

/* sv/tmq_ram.sv */
// ----------------------------------------------------------------------------
// tmq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmq_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/multi_timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// multi_timer_expiry_queue
// Pool of timer slots with a deadline-sorted list of running timers.
// ----------------------------------------------------------------------------
// Commands enter on func/timer_index/timeout/tag under cmd_valid/cmd_stall;
// results leave on kind/slot_id/expiry_tag/last under res_valid/res_stall.
// One command is worked on at a time; cmd_stall is high while it runs.
// The running list sits in a ring-addressed order RAM; deadlines sit in a RAM
// indexed by slot. Tags and slot status are registers. Every list step is a
// registered RAM read. Set tag, ignored commands, free of a slot that is not
// running and tick on an empty list complete in idle. A tick reads the due
// timers in list order and stops at the first one not due, at the list end
// or after MAX_OUT expiries; start scans the list, then shifts entries up;
// free of a running slot scans the list, then shifts entries down. Head
// removal after a tick only moves the ring head; no entries are moved.
// Results go through one output register; while it is full and res_stall is
// high the block holds its next result and waits. After reset the tick
// count is zero, all slots are free with tag zero and the list is empty;
// no clearing pass runs.
// ----------------------------------------------------------------------------
module multi_timer_expiry_queue
    import tmq_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [SLOT_ID_W-1:0] timer_index,
    input  logic [TIME_W-1:0]    timeout,
    input  logic [TAG_W-1:0]     tag,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [KIND_W-1:0]    kind,
    output logic [SLOT_ID_W-1:0] slot_id,
    output logic [TAG_W-1:0]     expiry_tag,
    output logic                 last
);

    localparam int IW      = $clog2(SLOTS);
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int MAX_HIT = (SLOTS < MAX_OUT) ? SLOTS : MAX_OUT;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_ORD = 9'b000000010,
        S_SCAN_DL  = 9'b000000100,
        S_FLUSH    = 9'b000001000,
        S_SH_RD    = 9'b000010000,
        S_SH_WR    = 9'b000100000,
        S_FIND     = 9'b001000000,
        S_DN_RD    = 9'b010000000,
        S_DN_WR    = 9'b100000000
    } fsm_t;

    fsm_t state_reg, state_next;
    logic [TIME_W-1:0]  tick_reg, tick_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      q_reg, q_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [TIME_W-1:0]  new_dl_reg, new_dl_next;
    logic               mode_tick_reg, mode_tick_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [KIND_W-1:0]  hold_kind_reg, hold_kind_next;
    logic [IW-1:0]      hold_slot_reg, hold_slot_next;
    logic [TAG_W-1:0]   hold_tag_reg, hold_tag_next;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [SLOT_ID_W-1:0] out_slot_reg, out_slot_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic               out_last_reg, out_last_next;
    slot_st_t           status_reg [SLOTS];
    slot_st_t           status_next [SLOTS];
    logic [TAG_W-1:0]   slot_tag_reg [SLOTS];
    logic [TAG_W-1:0]   slot_tag_next [SLOTS];

    logic               ord_we, ord_re;
    logic [IW-1:0]      ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic               dl_we, dl_re;
    logic [IW-1:0]      dl_waddr, dl_raddr;
    logic [TIME_W-1:0]  dl_wdata, dl_rdata;

    logic               free_found;
    logic [IW-1:0]      free_idx;
    logic               out_free;
    logic               in_range;
    logic [IW-1:0]      idx_in;
    logic [CW-1:0]      pos_inc;
    logic [TAG_W-1:0]   cur_tag;
    logic [TIME_W-1:0]  start_dl;

    // Logical list position to ring address.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(p);
        if (s >= (CW+1)'(SLOTS))
        begin
            s = s - (CW+1)'(SLOTS);
        end
        return s[IW-1:0];
    endfunction

    tmq_ram #(.W(IW), .D(SLOTS)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata)
    );

    tmq_ram #(.W(TIME_W), .D(SLOTS)) u_deadline (
        .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .re(dl_re), .raddr(dl_raddr), .rdata(dl_rdata)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == SLOT_FREE)
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign out_free  = !out_valid_reg || !res_stall;
    assign in_range  = (32'(timer_index) < 32'(SLOTS));
    assign idx_in    = IW'(timer_index);
    assign pos_inc   = pos_reg + CW'(1);
    assign cur_tag   = slot_tag_reg[cur_reg];
    assign start_dl  = tick_reg + timeout;
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        pos_next        = pos_reg;
        q_next          = q_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        new_dl_next     = new_dl_reg;
        mode_tick_next  = mode_tick_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_slot_next  = hold_slot_reg;
        hold_tag_next   = hold_tag_reg;
        status_next     = status_reg;
        slot_tag_next   = slot_tag_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0;
        ord_re = 1'b0; ord_raddr = '0;
        dl_we  = 1'b0; dl_waddr  = '0; dl_wdata  = '0;
        dl_re  = 1'b0; dl_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (func)
                        FN_TICK:
                        begin
                            tick_next      = tick_reg + 32'd1;
                            mode_tick_next = 1'b1;
                            pos_next       = '0;
                            if (count_reg != '0)
                            begin
                                ord_re     = 1'b1;
                                ord_raddr  = head_reg;
                                state_next = S_SCAN_ORD;
                            end
                        end
                        FN_ALLOC:
                        begin
                            hold_valid_next = 1'b1;
                            hold_tag_next   = '0;
                            pos_next        = '0;
                            if (free_found)
                            begin
                                status_next[free_idx] = SLOT_ALLOC;
                                hold_kind_next        = KD_GRANT;
                                hold_slot_next        = free_idx;
                            end
                            else
                            begin
                                hold_kind_next = KD_NONE;
                                hold_slot_next = '0;
                            end
                            state_next = S_FLUSH;
                        end
                        FN_FREE:
                        begin
                            if (in_range)
                            begin
                                if (status_reg[idx_in] == SLOT_RUN)
                                begin
                                    idx_next   = idx_in;
                                    pos_next   = '0;
                                    ord_re     = 1'b1;
                                    ord_raddr  = head_reg;
                                    state_next = S_FIND;
                                end
                                status_next[idx_in] = SLOT_FREE;
                            end
                        end
                        FN_SETTAG:
                        begin
                            if (in_range)
                            begin
                                slot_tag_next[idx_in] = tag;
                            end
                        end
                        FN_START:
                        begin
                            if (in_range && status_reg[idx_in] == SLOT_ALLOC)
                            begin
                                dl_we               = 1'b1;
                                dl_waddr            = idx_in;
                                dl_wdata            = start_dl;
                                new_dl_next         = start_dl;
                                idx_next            = idx_in;
                                status_next[idx_in] = SLOT_RUN;
                                mode_tick_next      = 1'b0;
                                pos_next            = '0;
                                if (count_reg == '0)
                                begin
                                    q_next     = '0;
                                    state_next = S_SH_RD;
                                end
                                else
                                begin
                                    ord_re     = 1'b1;
                                    ord_raddr  = head_reg;
                                    state_next = S_SCAN_ORD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_ORD:
            begin
                cur_next   = ord_rdata;
                dl_re      = 1'b1;
                dl_raddr   = ord_rdata;
                state_next = S_SCAN_DL;
            end
            S_SCAN_DL:
            begin
                if (mode_tick_reg)
                begin
                    if (dl_rdata > tick_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (!hold_valid_reg || out_free)
                    begin
                        // The previous expiry is known not to be the final one.
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = hold_kind_reg;
                            out_slot_next  = SLOT_ID_W'(hold_slot_reg);
                            out_tag_next   = hold_tag_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next      = 1'b1;
                        hold_kind_next       = KD_EXPIRED;
                        hold_slot_next       = cur_reg;
                        hold_tag_next        = cur_tag;
                        status_next[cur_reg] = SLOT_ALLOC;
                        pos_next             = pos_inc;
                        if (pos_inc < count_reg && pos_inc < CW'(MAX_HIT))
                        begin
                            ord_re     = 1'b1;
                            ord_raddr  = phys(head_reg, pos_inc);
                            state_next = S_SCAN_ORD;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
                else
                begin
                    if (new_dl_reg > dl_rdata)
                    begin
                        pos_next = pos_inc;
                        if (pos_inc < count_reg)
                        begin
                            ord_re     = 1'b1;
                            ord_raddr  = phys(head_reg, pos_inc);
                            state_next = S_SCAN_ORD;
                        end
                        else
                        begin
                            q_next     = count_reg;
                            state_next = S_SH_RD;
                        end
                    end
                    else
                    begin
                        q_next     = count_reg;
                        state_next = S_SH_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = hold_kind_reg;
                    out_slot_next   = SLOT_ID_W'(hold_slot_reg);
                    out_tag_next    = hold_tag_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    head_next       = phys(head_reg, pos_reg);
                    count_next      = count_reg - pos_reg;
                    state_next      = S_IDLE;
                end
            end
            S_SH_RD:
            begin
                if (q_reg > pos_reg)
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = phys(head_reg, q_reg - CW'(1));
                    state_next = S_SH_WR;
                end
                else
                begin
                    ord_we     = 1'b1;
                    ord_waddr  = phys(head_reg, pos_reg);
                    ord_wdata  = idx_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                ord_we     = 1'b1;
                ord_waddr  = phys(head_reg, q_reg);
                ord_wdata  = ord_rdata;
                q_next     = q_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_FIND:
            begin
                if (ord_rdata == idx_reg)
                begin
                    q_next     = pos_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    pos_next  = pos_inc;
                    ord_re    = 1'b1;
                    ord_raddr = phys(head_reg, pos_inc);
                end
            end
            S_DN_RD:
            begin
                if (q_reg + CW'(1) < count_reg)
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = phys(head_reg, q_reg + CW'(1));
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_IDLE;
                end
            end
            S_DN_WR:
            begin
                ord_we     = 1'b1;
                ord_waddr  = phys(head_reg, q_reg);
                ord_wdata  = ord_rdata;
                q_next     = q_reg + CW'(1);
                state_next = S_DN_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i]   <= SLOT_FREE;
                slot_tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            slot_tag_reg   <= slot_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        q_reg         <= q_next;
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        new_dl_reg    <= new_dl_next;
        mode_tick_reg <= mode_tick_next;
        hold_kind_reg <= hold_kind_next;
        hold_slot_reg <= hold_slot_next;
        hold_tag_reg  <= hold_tag_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
    end

    assign res_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign slot_id    = out_slot_reg;
    assign expiry_tag = out_tag_reg;
    assign last       = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("running count exceeds slot count");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("held result left behind in idle");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && func == FN_TICK) |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick count did not advance by one");

endmodule

/* tb/timer_queue_checker.sv */
// ----------------------------------------------------------------------------
// timer_queue_checker
// Watches both channels of the timer queue and checks every result item.
// ----------------------------------------------------------------------------
// Each accepted command is applied to a private copy of the slot pool and the
// sorted running list. The results it causes are queued and compared, field by
// field, with the results the block hands out, oldest first.
// ----------------------------------------------------------------------------
module timer_queue_checker
    import tmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [SLOT_ID_W-1:0] timer_index,
    input  logic [TIME_W-1:0]    timeout,
    input  logic [TAG_W-1:0]     tag,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [SLOT_ID_W-1:0] slot_id,
    input  logic [TAG_W-1:0]     expiry_tag,
    input  logic                 last,
    output int                   errors,
    output int                   pending_results,
    output int                   expired_seen,
    output int                   full_seen
);

    localparam int NSLOT = 32;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SLOT_ID_W-1:0] slot;
        logic [TAG_W-1:0]     tg;
        logic                 fin;
    } result_t;

    result_t          due_results[$];
    logic [TIME_W-1:0] now_count;
    slot_st_t         status[NSLOT];
    logic [TIME_W-1:0] deadline[NSLOT];
    logic [TAG_W-1:0] tags[NSLOT];
    int               run_list[$];

    assign pending_results = due_results.size();

    task automatic apply_command(input logic [FUNC_W-1:0] f, input logic [SLOT_ID_W-1:0] ix,
                                 input logic [TIME_W-1:0] tmo, input logic [TAG_W-1:0] tg);
        int n;
        int p;
        int s;
        result_t r;
        if (f == FN_TICK) begin
            now_count = now_count + 1;
            n = 0;
            while (n < run_list.size() && n < MAX_OUT) begin
                s = run_list[n];
                if (deadline[s] > now_count) break;
                status[s] = SLOT_ALLOC;
                r = '{KD_EXPIRED, SLOT_ID_W'(s), tags[s], 1'b0};
                due_results.push_back(r);
                n++;
            end
            if (n > 0) begin
                r = due_results.pop_back();
                r.fin = 1'b1;
                due_results.push_back(r);
                repeat (n) void'(run_list.pop_front());
            end
        end else if (f == FN_ALLOC) begin
            r = '{KD_NONE, '0, '0, 1'b1};
            for (s = 0; s < NSLOT; s++) begin
                if (status[s] == SLOT_FREE) begin
                    status[s] = SLOT_ALLOC;
                    r = '{KD_GRANT, SLOT_ID_W'(s), '0, 1'b1};
                    break;
                end
            end
            due_results.push_back(r);
        end else if (f == FN_FREE) begin
            if (status[ix] == SLOT_RUN) begin
                for (p = 0; p < run_list.size(); p++) begin
                    if (run_list[p] == ix) begin
                        run_list.delete(p);
                        break;
                    end
                end
            end
            status[ix] = SLOT_FREE;
        end else if (f == FN_SETTAG) begin
            tags[ix] = tg;
        end else if (f == FN_START) begin
            if (status[ix] == SLOT_ALLOC) begin
                deadline[ix] = now_count + tmo;
                status[ix] = SLOT_RUN;
                p = 0;
                while (p < run_list.size() && deadline[ix] > deadline[run_list[p]]) p++;
                run_list.insert(p, int'(ix));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            errors = 0;
            expired_seen = 0;
            full_seen = 0;
            now_count = '0;
            due_results.delete();
            run_list.delete();
            for (int i = 0; i < NSLOT; i++) begin
                status[i] = SLOT_FREE;
                deadline[i] = '0;
                tags[i] = '0;
            end
        end else begin
            // Results are compared before the command of the same edge is applied,
            // since a result can never come from a command accepted at that edge.
            if (res_valid && !res_stall) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: kind %0d slot %0d tag %0d last %0d",
                                 kind, slot_id, expiry_tag, last);
                end else begin
                    want = due_results.pop_front();
                    if (kind == KD_EXPIRED) expired_seen++;
                    if (kind == KD_NONE) full_seen++;
                    if (kind !== want.kind || slot_id !== want.slot
                        || expiry_tag !== want.tg || last !== want.fin) begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.kind, want.slot, want.tg, want.fin,
                                     kind, slot_id, expiry_tag, last);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                apply_command(func, timer_index, timeout, tag);
        end
    end

endmodule

/* tb/multi_timer_expiry_queue_test.sv */
// ----------------------------------------------------------------------------
// multi_timer_expiry_queue_test
// Stimulus and verdict for the multi-timer expiry queue.
// ----------------------------------------------------------------------------
// Directed commands cover every operation, full pool, tag extremes, equal and
// wrapping deadlines and freeing slots. Random scenarios then keep
// many slots allocated and running with small timeouts so that ticks fire
// often, with the sender in bursts and the receiver stalling on its own.
// ----------------------------------------------------------------------------
module multi_timer_expiry_queue_test;
    import tmq_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    logic [FUNC_W-1:0]    func;
    logic [SLOT_ID_W-1:0] timer_index;
    logic [TIME_W-1:0]    timeout;
    logic [TAG_W-1:0]     tag;
    logic                 res_valid;
    logic                 res_stall;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [TAG_W-1:0]     expiry_tag;
    logic                 last;
    int                   errors;
    int                   pending_results;
    int                   expired_seen;
    int                   full_seen;
    int                   sent;
    int                   idle_cycles;
    bit                   stim_done;

    multi_timer_expiry_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .func(func), .timer_index(timer_index), .timeout(timeout), .tag(tag),
        .res_valid(res_valid), .res_stall(res_stall),
        .kind(kind), .slot_id(slot_id), .expiry_tag(expiry_tag), .last(last)
    );

    timer_queue_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .func(func), .timer_index(timer_index), .timeout(timeout), .tag(tag),
        .res_valid(res_valid), .res_stall(res_stall),
        .kind(kind), .slot_id(slot_id), .expiry_tag(expiry_tag), .last(last),
        .errors(errors), .pending_results(pending_results),
        .expired_seen(expired_seen), .full_seen(full_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stall: runs of random length, sometimes long, each stalled or not at random.
    initial
    begin
        int run;
        res_stall = 1'b0;
        forever
        begin
            run = $urandom_range(0, 3) == 0 ? $urandom_range(5, 25) : $urandom_range(1, 4);
            repeat (run) @(negedge clk);
            res_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Watchdog on cycles in which neither channel accepts anything.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)
            || (stim_done && pending_results == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    int burst_left;

    task automatic send(input logic [FUNC_W-1:0] f, input int ix,
                        input logic [TIME_W-1:0] tmo, input logic [TAG_W-1:0] tg);
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        cmd_valid   <= 1'b1;
        func        <= f;
        timer_index <= SLOT_ID_W'(ix);
        timeout     <= tmo;
        tag         <= tg;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent++;
    endtask

    initial
    begin
        int r;
        int w;
        idle_cycles = 0;
        stim_done = 1'b0;
        sent = 0;
        burst_left = 0;
        cmd_valid = 1'b0;
        func = FN_TICK;
        timer_index = '0;
        timeout = '0;
        tag = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part.
        send(FN_TICK, 0, '0, '0);
        send(FN_START, 0, 32'd1, '0);          // start on a free slot is ignored
        send(FN_ALLOC, 0, '0, '0);
        send(FN_ALLOC, 0, '0, '0);
        send(FN_ALLOC, 0, '0, '0);
        send(FN_SETTAG, 0, '0, 8'hFF);
        send(FN_SETTAG, 1, '0, 8'h00);
        send(FN_SETTAG, 2, '0, 8'hA5);
        send(FN_START, 0, 32'd2, '0);
        send(FN_START, 1, 32'd2, '0);          // equal deadline, later start first
        send(FN_START, 1, 32'd9, '0);          // running slot: ignored
        send(FN_START, 2, 32'hFFFF_FFFF, '0);  // wraps, sorts early
        send(FN_START, 31, 32'd0, '0);         // slot 31 never allocated
        send(FN_TICK, 0, '0, '0);
        send(FN_TICK, 0, '0, '0);
        send(FN_FREE, 2, '0, '0);              // free an allocated slot whose timer expired
        send(FN_FREE, 2, '0, '0);              // free a free slot
        send(3'd7, 31, 32'hFFFF_FFFF, 8'hFF);  // unknown command
        send(3'd5, 0, '0, '0);
        for (int i = 0; i < 31; i++) send(FN_ALLOC, 0, '0, '0);  // fills pool, then none
        for (int i = 0; i < 32; i++) send(FN_START, i, 32'd1, 8'(i));
        send(FN_TICK, 0, '0, '0);              // all 32 due at once

        // Random part: mostly start/tick traffic on a busy pool.
        while (sent < 320)
        begin
            r = $urandom_range(0, 99);
            if (r < 28) send(FN_TICK, 0, '0, '0);
            else if (r < 40) send(FN_ALLOC, 0, '0, '0);
            else if (r < 50) send(FN_FREE, $urandom_range(0, 31), '0, '0);
            else if (r < 60) send(FN_SETTAG, $urandom_range(0, 31), '0, 8'($urandom));
            else if (r < 95)
            begin
                w = $urandom_range(0, 9);
                send(FN_START, $urandom_range(0, 31),
                     w == 0 ? $urandom : (w == 1 ? 32'hFFFF_FFF0 | $urandom_range(0, 15)
                                                : $urandom_range(0, 6)), 8'($urandom));
            end
            else send(3'($urandom_range(5, 7)), $urandom_range(0, 31), $urandom, 8'($urandom));
        end
        cmd_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Sent %0d commands; saw %0d expiries and %0d pool-full replies.",
                 sent, expired_seen, full_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/tmq_pkg.sv
sv/tmq_ram.sv
sv/multi_timer_expiry_queue.sv
tb/timer_queue_checker.sv
tb/multi_timer_expiry_queue_test.sv
